[rtl/core/fett_pkg.sv]
// Shared constants, record types and the sequencer state type for the
// flow extent transit time block. No dependencies.
package fett_pkg;

    // Vector fields arrive FIELD_W wide; only the low COORD_WIDTH bits count.
    localparam int FIELD_W     = 24;
    localparam int COORD_WIDTH = 24;   // 8 .. 24
    localparam int THR_W       = 48;   // squared speed threshold, Q24.24
    localparam int OUT_W       = 32;   // transit time, Q16.16
    localparam int FRAC_SHIFT  = 16;

    localparam int PROD_W = 2 * COORD_WIDTH;       // one product
    localparam int PROJ_W = 2 * COORD_WIDTH + 2;   // sum of three products
    localparam int SSQ_W  = 2 * COORD_WIDTH;       // squared speed
    localparam int QUO_W  = 2 * FRAC_SHIFT;        // quotient bits produced
    localparam int CNT_W  = $clog2(QUO_W);

    // Cell queue; depth must be a power of two.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic signed [PROJ_W-1:0] PROJ_MIN = {1'b1, {(PROJ_W-1){1'b0}}};
    localparam logic signed [PROJ_W-1:0] PROJ_MAX = {1'b0, {(PROJ_W-1){1'b1}}};

    // One finished cell, handed from front to back.
    typedef struct packed {
        logic [PROJ_W-1:0] diff;        // max - min projection
        logic [SSQ_W-1:0]  ssq;         // |U|^2 of the last vertex
        logic              stationary;
    } t_cell_rec;

    typedef struct packed {
        logic      valid;
        t_cell_rec rec;
    } t_rec_xfer;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } t_back_state;

endpackage

[rtl/core/fett_if.sv]
// Channel interfaces: vertex input and cell result.
// Depends on fett_pkg.
interface fett_vtx_if;
    logic                             valid;
    logic                             ready;
    logic signed [fett_pkg::FIELD_W-1:0] vel_x;
    logic signed [fett_pkg::FIELD_W-1:0] vel_y;
    logic signed [fett_pkg::FIELD_W-1:0] vel_z;
    logic signed [fett_pkg::FIELD_W-1:0] pos_x;
    logic signed [fett_pkg::FIELD_W-1:0] pos_y;
    logic signed [fett_pkg::FIELD_W-1:0] pos_z;
    logic                             last_vertex;

    modport source (output valid, vel_x, vel_y, vel_z, pos_x, pos_y, pos_z, last_vertex,
                    input ready);
    modport sink   (input valid, vel_x, vel_y, vel_z, pos_x, pos_y, pos_z, last_vertex,
                    output ready);
endinterface

interface fett_res_if;
    logic                          valid;
    logic                          ready;
    logic [fett_pkg::OUT_W-1:0]    transit_time;
    logic                          stationary;

    modport source (output valid, transit_time, stationary, input ready);
    modport sink   (input valid, transit_time, stationary, output ready);
endinterface

[rtl/core/fett_front.sv]
// Front end: vertex projection pipeline, running extremes, cell records.
// Depends on fett_pkg and fett_if.
module fett_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [fett_pkg::THR_W-1:0]    i_cfg_wdata,
    fett_vtx_if.sink                      i_vtx,
    input  logic                          i_q_full,
    output fett_pkg::t_rec_xfer           o_push
);
    localparam int C  = fett_pkg::COORD_WIDTH;
    localparam int PW = fett_pkg::PROD_W;
    localparam int JW = fett_pkg::PROJ_W;
    localparam int SW = fett_pkg::SSQ_W;

    logic [fett_pkg::THR_W-1:0] r_thr;

    // stage 1: products
    logic                 r_s1_valid, r_s1_last;
    logic signed [PW-1:0] r_px, r_py, r_pz, r_sx, r_sy, r_sz;
    // stage 2: projection and squared speed
    logic                 r_s2_valid, r_s2_last;
    logic signed [JW-1:0] r_proj;
    logic [SW-1:0]        r_ssq;
    // running extremes
    logic signed [JW-1:0] r_max, r_min;
    logic signed [JW-1:0] n_max, n_min;

    logic                adv;
    logic signed [C-1:0] ux, uy, uz, px, py, pz;
    logic signed [JW-1:0] n_proj;
    logic [SW-1:0]        n_ssq;

    // Whole pipeline holds while a finished cell waits for queue space.
    assign adv         = !(r_s2_valid && r_s2_last && i_q_full);
    assign i_vtx.ready = adv;

    assign ux = $signed(i_vtx.vel_x[C-1:0]);
    assign uy = $signed(i_vtx.vel_y[C-1:0]);
    assign uz = $signed(i_vtx.vel_z[C-1:0]);
    assign px = $signed(i_vtx.pos_x[C-1:0]);
    assign py = $signed(i_vtx.pos_y[C-1:0]);
    assign pz = $signed(i_vtx.pos_z[C-1:0]);

    assign n_proj = JW'(r_px) + JW'(r_py) + JW'(r_pz);
    assign n_ssq  = SW'($unsigned(r_sx)) + SW'($unsigned(r_sy)) + SW'($unsigned(r_sz));

    assign n_max = (r_proj > r_max) ? r_proj : r_max;
    assign n_min = (r_proj < r_min) ? r_proj : r_min;

    always_comb begin
        o_push.valid          = r_s2_valid && r_s2_last && adv;
        o_push.rec.diff       = $unsigned(n_max - n_min);
        o_push.rec.ssq        = r_ssq;
        o_push.rec.stationary = fett_pkg::THR_W'(r_ssq) <= r_thr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= '0;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_max      <= fett_pkg::PROJ_MIN;
            r_min      <= fett_pkg::PROJ_MAX;
        end else if (adv) begin
            r_s1_valid <= i_vtx.valid;
            r_s2_valid <= r_s1_valid;
            if (r_s2_valid) begin
                if (r_s2_last) begin
                    r_max <= fett_pkg::PROJ_MIN;
                    r_min <= fett_pkg::PROJ_MAX;
                end else begin
                    r_max <= n_max;
                    r_min <= n_min;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_last <= i_vtx.last_vertex;
            r_px      <= PW'(ux * px);
            r_py      <= PW'(uy * py);
            r_pz      <= PW'(uz * pz);
            r_sx      <= PW'(ux * ux);
            r_sy      <= PW'(uy * uy);
            r_sz      <= PW'(uz * uz);
            r_s2_last <= r_s1_last;
            r_proj    <= n_proj;
            r_ssq     <= n_ssq;
        end
    end

endmodule

[rtl/core/fett_queue.sv]
// Short queue of finished cell records between front and back.
// Depends on fett_pkg.
module fett_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  fett_pkg::t_rec_xfer  i_push,
    input  logic                 i_pop,
    output fett_pkg::t_rec_xfer  o_head,
    output logic                 o_full
);
    fett_pkg::t_cell_rec r_mem [fett_pkg::QUEUE_DEPTH];
    logic [fett_pkg::QPTR_W-1:0] r_wr, r_rd;
    logic [fett_pkg::QCNT_W-1:0] r_cnt;

    assign o_full       = r_cnt == fett_pkg::QCNT_W'(fett_pkg::QUEUE_DEPTH);
    assign o_head.valid = r_cnt != '0;
    assign o_head.rec   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr] <= i_push.rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push.valid, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

[rtl/core/fett_back.sv]
// Back end: per-cell saturation checks, radix-2 restoring divider and
// output register. Depends on fett_pkg and fett_if.
module fett_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  fett_pkg::t_rec_xfer  i_head,
    output logic                 o_pop,
    fett_res_if.source           o_res
);
    localparam int SW = fett_pkg::SSQ_W;
    localparam int QW = fett_pkg::QUO_W;
    localparam int FS = fett_pkg::FRAC_SHIFT;

    fett_pkg::t_back_state r_state, n_state;

    logic [SW-1:0]             r_ssq, r_rem;
    logic [QW-1:0]             r_num, r_quo;
    logic [fett_pkg::CNT_W-1:0] r_cnt;
    logic                      r_stat;
    logic                      r_out_valid;
    logic [fett_pkg::OUT_W-1:0] r_out_time;
    logic                      r_out_stat;

    logic          ovf, sat, step, load;
    logic [SW:0]   trial;
    logic [SW+1:0] sub;
    logic          ge;

    // Quotient fits in 32 bits only when diff >> 16 is below |U|^2.
    assign ovf = SW'(i_head.rec.diff >> FS) >= i_head.rec.ssq;
    assign sat = i_head.rec.stationary || ovf;

    assign trial = {r_rem, r_num[QW-1]};
    assign sub   = {1'b0, trial} - {2'b00, r_ssq};
    assign ge    = !sub[SW+1];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fett_pkg::ST_IDLE: begin
                if (i_head.valid) begin
                    n_state = sat ? fett_pkg::ST_DONE : fett_pkg::ST_DIV;
                end
            end
            fett_pkg::ST_DIV: begin
                if (r_cnt == '0) begin
                    n_state = fett_pkg::ST_DONE;
                end
            end
            fett_pkg::ST_DONE: begin
                if (!r_out_valid || o_res.ready) begin
                    n_state = fett_pkg::ST_IDLE;
                end
            end
            default: n_state = fett_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_pop = 1'b0;
        step  = 1'b0;
        load  = 1'b0;
        unique case (r_state)
            fett_pkg::ST_IDLE: o_pop = i_head.valid;
            fett_pkg::ST_DIV:  step  = 1'b1;
            fett_pkg::ST_DONE: load  = !r_out_valid || o_res.ready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fett_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ssq  <= i_head.rec.ssq;
            r_rem  <= SW'(i_head.rec.diff >> FS);
            r_num  <= {i_head.rec.diff[FS-1:0], {FS{1'b0}}};
            r_quo  <= sat ? '1 : '0;
            r_stat <= i_head.rec.stationary;
            r_cnt  <= fett_pkg::CNT_W'(QW - 1);
        end else if (step) begin
            r_rem <= ge ? sub[SW-1:0] : trial[SW-1:0];
            r_num <= {r_num[QW-2:0], 1'b0};
            r_quo <= {r_quo[QW-2:0], ge};
            r_cnt <= r_cnt - 1'b1;
        end
        if (load) begin
            r_out_time <= fett_pkg::OUT_W'(r_quo);
            r_out_stat <= r_stat;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.transit_time = r_out_time;
    assign o_res.stationary   = r_out_stat;

endmodule

[rtl/core/flow_extent_transit_time_unit.sv]
// Flow extent transit time: top level, joins front, cell queue and back.
// Depends on fett_pkg, fett_if, fett_front, fett_queue, fett_back.
//
// Usage:
//   i_vtx streams one vertex per item (velocity, position, last_vertex),
//   valid/ready handshake, accepted when both are high. The front accepts
//   one vertex every cycle while ready is high: three projection and three
//   square products, a sum stage, then the running max/min update.
//   On a vertex marked last, a cell record (max - min, |U|^2, stationary
//   flag) enters a two-deep queue and the extremes return to their reset
//   values. The back pops a record and runs a radix-2 restoring divider,
//   one quotient bit per cycle; stationary or overflowing cells skip the
//   divider and give all ones. A last vertex passes the product and sum
//   stages into the queue; the back pops its record, divides if needed,
//   loads the output register, and pops the next record only after that load.
//   o_res is a registered result; while it is stalled the divider still
//   finishes the next cell, and the queue still takes records. Only when
//   the queue is full does i_vtx.ready drop, and only while a finished
//   cell waits at the end of the front pipeline for a free slot.
//   i_cfg_we writes the 48-bit squared speed threshold; write it idle.
//   Reset (synchronous, active low) empties the queue, clears the
//   threshold, resets the extremes and drops all valids.
module flow_extent_transit_time_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [fett_pkg::THR_W-1:0] i_cfg_wdata,
    fett_vtx_if.sink                   i_vtx,
    fett_res_if.source                 o_res
);
    fett_pkg::t_rec_xfer push, head;
    logic                q_full;
    logic                pop;

    fett_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_vtx       (i_vtx),
        .i_q_full    (q_full),
        .o_push      (push)
    );

    fett_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_head  (head),
        .o_full  (q_full)
    );

    fett_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_res   (o_res)
    );

`ifndef SYNTHESIS
    // front never writes a record into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.valid |-> !q_full)
        else $error("cell queue overflow");

    // back only pops a record that is there
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> head.valid)
        else $error("cell queue underflow");

    // a pop always frees a slot for the stalled front
    a_pop_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |=> !q_full)
        else $error("queue still full after pop");
`endif

endmodule

[tb/sv/flow_extent_transit_time_unit_checker.sv]
// Scoreboard for the flow extent transit time block: watches the vertex and
// result channels, predicts each cell result and compares it on arrival.
// Depends on fett_pkg and fett_if.
module flow_extent_transit_time_unit_checker
    import fett_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [THR_W-1:0] i_cfg_wdata,
    fett_vtx_if              i_vtx,
    fett_res_if              i_res,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_cells,
    output int               o_stationary_cells,
    output int               o_saturated_cells
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [OUT_W-1:0] transit_time;
        logic             stationary;
    } cell_result_t;

    cell_result_t     pending_cells[$];
    logic [THR_W-1:0] speed_sq_thr;
    longint           proj_hi;
    longint           proj_lo;

    // Low COORD_WIDTH bits as two's complement.
    function automatic longint coord_value(input logic [FIELD_W-1:0] raw);
        longint v;
        v = longint'(raw[COORD_WIDTH-1:0]);
        return (v <<< (64 - COORD_WIDTH)) >>> (64 - COORD_WIDTH);
    endfunction

    // Folds one vertex into the running extremes; returns 1 with the cell
    // result when the vertex closes the cell.
    function automatic bit fold_vertex(output cell_result_t res);
        longint            ux, uy, uz, px, py, pz, proj;
        longint unsigned   ssq, diff, quo, rem;
        ux   = coord_value(i_vtx.vel_x);
        uy   = coord_value(i_vtx.vel_y);
        uz   = coord_value(i_vtx.vel_z);
        px   = coord_value(i_vtx.pos_x);
        py   = coord_value(i_vtx.pos_y);
        pz   = coord_value(i_vtx.pos_z);
        proj = ux * px + uy * py + uz * pz;
        if (proj > proj_hi) begin
            proj_hi = proj;
        end
        if (proj < proj_lo) begin
            proj_lo = proj;
        end
        res = '0;
        if (!i_vtx.last_vertex) begin
            return 1'b0;
        end
        ssq = longint'(ux * ux + uy * uy + uz * uz);
        res.stationary = (ssq <= longint'(speed_sq_thr));
        if (res.stationary) begin
            res.transit_time = '1;
        end else begin
            diff = proj_hi - proj_lo;
            quo  = diff / ssq;
            rem  = diff % ssq;
            if (quo >= (64'd1 << FRAC_SHIFT)) begin
                res.transit_time = '1;
            end else begin
                res.transit_time = OUT_W'((quo << FRAC_SHIFT) + ((rem << FRAC_SHIFT) / ssq));
            end
        end
        proj_hi = longint'(PROJ_MIN);
        proj_lo = longint'(PROJ_MAX);
        return 1'b1;
    endfunction

    task automatic note_failure(input string what, input cell_result_t want,
                                input cell_result_t got);
        if (o_fail_count < REPORT_LIMIT) begin
            $display("[%0t] %s: expected time %h stationary %b, got time %h stationary %b",
                     $realtime, what, want.transit_time, want.stationary,
                     got.transit_time, got.stationary);
        end
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        cell_result_t want;
        cell_result_t got;
        if (!i_rst_n) begin
            pending_cells.delete();
            speed_sq_thr       = '0;
            proj_hi            = longint'(PROJ_MIN);
            proj_lo            = longint'(PROJ_MAX);
            o_fail_count       = 0;
            o_cells            = 0;
            o_stationary_cells = 0;
            o_saturated_cells  = 0;
        end else begin
            if (i_cfg_we) begin
                speed_sq_thr = i_cfg_wdata;
            end
            if (i_vtx.valid && i_vtx.ready) begin
                if (fold_vertex(want)) begin
                    pending_cells.push_back(want);
                end
            end
            if (i_res.valid && i_res.ready) begin
                got.transit_time = i_res.transit_time;
                got.stationary   = i_res.stationary;
                if (pending_cells.size() == 0) begin
                    note_failure("result with no cell pending", '0, got);
                end else begin
                    want = pending_cells.pop_front();
                    o_cells++;
                    if (want.stationary) begin
                        o_stationary_cells++;
                    end else if (&want.transit_time) begin
                        o_saturated_cells++;
                    end
                    if (got.transit_time !== want.transit_time ||
                        got.stationary !== want.stationary) begin
                        note_failure("cell result mismatch", want, got);
                    end
                end
            end
        end
        o_pending = pending_cells.size();
    end

endmodule

[tb/sv/flow_extent_transit_time_unit_tb.sv]
// Top of the flow extent transit time testbench: clock, reset, vertex
// stimulus, result back-pressure, threshold phases and the verdict.
// Depends on fett_pkg, fett_if, the block and its checker.
module flow_extent_transit_time_unit_tb;
    import fett_pkg::*;

    localparam int RESET_CYCLES   = 10;
    localparam int RANDOM_ITEMS   = 1050;
    localparam int N_PHASES       = 5;
    // Drain pause after the last result, longer than the block's latency.
    localparam int DRAIN_CYCLES   = 64;
    // Long receiver hold-off, enough to fill the two-deep cell queue.
    localparam int PRESSURE_HOLD  = 600;
    // Longest quiet stretch of a correct run is the hold-off plus the drain
    // pause and a sender gap; allow several times that.
    localparam int WATCHDOG_LIMIT = 5000;

    localparam logic signed [FIELD_W-1:0] C_MIN = {1'b1, {(FIELD_W-1){1'b0}}};
    localparam logic signed [FIELD_W-1:0] C_MAX = {1'b0, {(FIELD_W-1){1'b1}}};

    logic             i_clk;
    logic             i_rst_n;
    logic             cfg_we;
    logic [THR_W-1:0] cfg_wdata;

    fett_vtx_if vtx_ch();
    fett_res_if res_ch();

    int fail_count;
    int pending_cells;
    int cells_checked;
    int stationary_cells;
    int saturated_cells;

    int items_sent;
    int burst_left;
    int idle_count;
    int thr_writes;
    logic pressure_req;

    flow_extent_transit_time_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_vtx       (vtx_ch),
        .o_res       (res_ch)
    );

    flow_extent_transit_time_unit_checker u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (cfg_we),
        .i_cfg_wdata        (cfg_wdata),
        .i_vtx              (vtx_ch),
        .i_res              (res_ch),
        .o_fail_count       (fail_count),
        .o_pending          (pending_cells),
        .o_cells            (cells_checked),
        .o_stationary_cells (stationary_cells),
        .o_saturated_cells  (saturated_cells)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    // Watchdog: consecutive cycles with no item moving on either channel.
    always @(posedge i_clk) begin
        if ((vtx_ch.valid && vtx_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            idle_count <= 0;
        end else begin
            idle_count <= idle_count + 1;
        end
    end

    initial begin : watchdog
        wait (idle_count >= WATCHDOG_LIMIT);
        $display("Watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    // Random signed value in [-2^k, 2^k - 1]: sign-extend from bit k.
    function automatic logic signed [FIELD_W-1:0] scaled_coord(input int k);
        int s;
        s = $urandom;
        s = (s <<< (31 - k)) >>> (31 - k);
        return s[FIELD_W-1:0];
    endfunction

    // Mostly scaled random, now and then an extreme or zero.
    function automatic logic signed [FIELD_W-1:0] pick_coord(input int k);
        case ($urandom_range(0, 15))
            0:       return C_MIN;
            1:       return C_MAX;
            2:       return '0;
            default: return scaled_coord(k);
        endcase
    endfunction

    // One vertex item. The sender runs in bursts; when a burst is used up it
    // drops valid for a random gap first. valid stays high between items of
    // a burst, payload changes at the falling edge after the handshake.
    task automatic send_vertex(input logic signed [FIELD_W-1:0] vx, vy, vz, px, py, pz,
                               input logic last);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
            @(negedge i_clk);
            vtx_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        @(negedge i_clk);
        vtx_ch.valid       <= 1'b1;
        vtx_ch.vel_x       <= vx;
        vtx_ch.vel_y       <= vy;
        vtx_ch.vel_z       <= vz;
        vtx_ch.pos_x       <= px;
        vtx_ch.pos_y       <= py;
        vtx_ch.pos_z       <= pz;
        vtx_ch.last_vertex <= last;
        do @(posedge i_clk); while (!(vtx_ch.valid && vtx_ch.ready));
        items_sent++;
    endtask

    // Stop offering, let every expected cell come back, then let the
    // pipeline settle for the block's latency.
    task automatic drain_block();
        @(negedge i_clk);
        vtx_ch.valid <= 1'b0;
        while (pending_cells != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Threshold is only written with the block idle.
    task automatic write_threshold(input logic [THR_W-1:0] thr);
        drain_block();
        cfg_we    <= 1'b1;
        cfg_wdata <= thr;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
        thr_writes++;
    endtask

    // Random cell: 1..8 vertices usually, sometimes a long one. Vertices
    // cluster around a base point with a random spread, so the extent over
    // speed ratio ranges from far below one up to saturation. A few cells
    // change velocity from vertex to vertex.
    task automatic send_random_cell();
        int n_vtx;
        int vel_k;
        int spread_k;
        bit vary_vel;
        logic signed [FIELD_W-1:0] vx, vy, vz, bx, by, bz;
        n_vtx    = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
        vary_vel = ($urandom_range(0, 9) == 0);
        vel_k    = $urandom_range(0, FIELD_W - 1);
        spread_k = $urandom_range(0, FIELD_W - 2);
        vx = pick_coord(vel_k);
        vy = pick_coord(vel_k);
        vz = pick_coord(vel_k);
        bx = pick_coord(FIELD_W - 1);
        by = pick_coord(FIELD_W - 1);
        bz = pick_coord(FIELD_W - 1);
        for (int i = 0; i < n_vtx; i++) begin
            if (vary_vel && i > 0) begin
                vel_k = $urandom_range(0, FIELD_W - 1);
                vx = pick_coord(vel_k);
                vy = pick_coord(vel_k);
                vz = pick_coord(vel_k);
            end
            // Offsets wrap at the field width, which is fine for stimulus.
            send_vertex(vx, vy, vz,
                        ($urandom_range(0, 31) == 0) ? pick_coord(FIELD_W - 1)
                                                     : bx + scaled_coord(spread_k),
                        by + scaled_coord(spread_k),
                        bz + scaled_coord(spread_k),
                        i == n_vtx - 1);
        end
    endtask

    // Receiver: switches among always-ready, coin-flip, mostly-ready and a fixed
    // stall pattern. On request it holds ready low for a long stretch so the
    // cell queue fills and the block pushes back on the vertex channel.
    initial begin : receiver
        int mode;
        int mode_left;
        int hold_left;
        bit pressure_done;
        logic rdy;
        mode          = 0;
        mode_left     = 0;
        hold_left     = 0;
        pressure_done = 1'b0;
        res_ch.ready  = 1'b0;
        forever begin
            @(negedge i_clk);
            if (pressure_req && !pressure_done) begin
                hold_left     = PRESSURE_HOLD;
                pressure_done = 1'b1;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 300);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else begin
                case (mode)
                    0:       rdy = 1'b1;
                    1:       rdy = ($urandom_range(0, 1) != 0);
                    2:       rdy = ($urandom_range(0, 3) != 0);
                    default: rdy = ((mode_left % 16) < 10);
                endcase
            end
            res_ch.ready <= rdy;
        end
    end

    initial begin : stimulus
        int phase_start;
        logic [THR_W-1:0] thr;
        // Every block input known from time zero.
        i_rst_n            = 1'b0;
        cfg_we             = 1'b0;
        cfg_wdata          = '0;
        vtx_ch.valid       = 1'b0;
        vtx_ch.vel_x       = '0;
        vtx_ch.vel_y       = '0;
        vtx_ch.vel_z       = '0;
        vtx_ch.pos_x       = '0;
        vtx_ch.pos_y       = '0;
        vtx_ch.pos_z       = '0;
        vtx_ch.last_vertex = 1'b0;
        pressure_req       = 1'b0;
        items_sent         = 0;
        burst_left         = 0;
        thr_writes         = 0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, threshold 2^20 so a unit velocity of 1024 sits exactly on it.
        write_threshold(THR_W'(1) << 20);
        // Single-vertex cell: zero extent.
        send_vertex(24'sd4096, 24'sd0, 24'sd0, 24'sd123, -24'sd456, 24'sd789, 1'b1);
        // Most negative velocity across opposite corners.
        send_vertex(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, 1'b0);
        send_vertex(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, 1'b1);
        // Most positive velocity, mixed extreme positions.
        send_vertex(C_MAX, C_MAX, C_MAX, C_MAX, C_MIN, C_MAX, 1'b0);
        send_vertex(C_MAX, C_MAX, C_MAX, C_MIN, C_MAX, C_MIN, 1'b0);
        send_vertex(C_MAX, C_MAX, C_MAX, 24'sd0, 24'sd0, 24'sd0, 1'b1);
        // Squared speed equal to the threshold: stationary.
        send_vertex(24'sd1024, 24'sd0, 24'sd0, C_MIN, 24'sd0, 24'sd0, 1'b0);
        send_vertex(24'sd1024, 24'sd0, 24'sd0, C_MAX, 24'sd0, 24'sd0, 1'b1);
        // Just above the threshold: moving, full-span extent.
        send_vertex(24'sd0, 24'sd0, -24'sd1025, 24'sd0, 24'sd0, C_MIN, 1'b0);
        send_vertex(24'sd0, 24'sd0, -24'sd1025, 24'sd0, 24'sd0, C_MAX, 1'b1);
        // Velocity changes within the cell; divisor from the last vertex.
        send_vertex(24'sd3000, -24'sd2000, 24'sd500, 24'sd100000, 24'sd200000,
                    -24'sd300000, 1'b0);
        send_vertex(-24'sd4000, 24'sd100, 24'sd7000, -24'sd50000, 24'sd0,
                    24'sd123456, 1'b0);
        send_vertex(24'sd2500, 24'sd2500, -24'sd2500, 24'sd7, 24'sd8, 24'sd9, 1'b1);

        // Directed, threshold zero: zero velocity and quotient overflow.
        write_threshold('0);
        send_vertex(24'sd0, 24'sd0, 24'sd0, C_MAX, C_MAX, C_MAX, 1'b0);
        send_vertex(24'sd0, 24'sd0, 24'sd0, C_MIN, C_MIN, C_MIN, 1'b1);
        // Unit speed over the full span: overflows by far.
        send_vertex(24'sd0, 24'sd0, 24'sd1, 24'sd0, 24'sd0, C_MIN, 1'b0);
        send_vertex(24'sd0, 24'sd0, 24'sd1, 24'sd0, 24'sd0, C_MAX, 1'b1);
        // Quotient exactly 2^16: first value that saturates.
        send_vertex(24'sd0, -24'sd200, 24'sd0, 24'sd0, -24'sd6553600, 24'sd0, 1'b0);
        send_vertex(24'sd0, -24'sd200, 24'sd0, 24'sd0, 24'sd6553600, 24'sd0, 1'b1);
        // One step shorter: largest unsaturated time.
        send_vertex(24'sd0, -24'sd200, 24'sd0, 24'sd0, -24'sd6553600, 24'sd0, 1'b0);
        send_vertex(24'sd0, -24'sd200, 24'sd0, 24'sd0, 24'sd6553599, 24'sd0, 1'b1);
        send_vertex(-24'sd1, 24'sd0, 24'sd0, C_MIN, C_MIN, C_MIN, 1'b1);

        // Random phases, one threshold each; the first carries the long
        // receiver hold-off. Each phase ends on a closed cell.
        for (int phase = 0; phase < N_PHASES; phase++) begin
            case (phase)
                0:       thr = THR_W'(1) << 30;
                1:       thr = '1;
                2:       thr = '0;
                3:       thr = (THR_W'(1) << $urandom_range(16, 46))
                               + THR_W'($urandom_range(0, 65535));
                default: thr = THR_W'({$urandom, $urandom});
            endcase
            write_threshold(thr);
            if (phase == 0) begin
                pressure_req <= 1'b1;
            end
            phase_start = items_sent;
            while (items_sent - phase_start < RANDOM_ITEMS / N_PHASES) begin
                send_random_cell();
            end
        end

        drain_block();
        $display("Run: %0d vertex items, %0d cells checked (%0d stationary, %0d saturated)",
                 items_sent, cells_checked, stationary_cells, saturated_cells);
        $display("     over %0d threshold settings, one %0d-cycle receiver hold-off",
                 thr_writes, PRESSURE_HOLD);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d failures", fail_count);
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/core/fett_pkg.sv
rtl/core/fett_if.sv
rtl/core/fett_front.sv
rtl/core/fett_queue.sv
rtl/core/fett_back.sv
rtl/core/flow_extent_transit_time_unit.sv
tb/sv/flow_extent_transit_time_unit_checker.sv
tb/sv/flow_extent_transit_time_unit_tb.sv
